FILE: hw/rtl/dba_pkg.sv
// Shared types and constants for the depth background accumulator.
// No dependencies; all other files but dba_ram refer to it by scoped names.
package dba_pkg;

  localparam int IDX_W   = 18;  // pixel index
  localparam int DEPTH_W = 16;  // depth / background value
  localparam int CFG_W   = 15;  // reliable-range bounds
  localparam int CFG_IDX_W = 1;

  // Running average: (99*bg + d + 50) / 100, division by reciprocal multiply.
  // m = ceil(2^30 / 100); error term 76 * sum_max stays below 2^30.
  localparam int SUM_W       = 23;
  localparam int RECIP_W     = 24;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int RECIP_SHIFT = 30;
  localparam logic [6:0]         AVG_WEIGHT = 7'd99;
  localparam logic [6:0]         ROUND_HALF = 7'd50;
  localparam logic [RECIP_W-1:0] RECIP_M    = 24'd10737419;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RELIABLE = 1'b0,
    REG_MAX_RELIABLE = 1'b1
  } dba_reg_t;

  // How the new background value is formed
  typedef enum logic [1:0] {
    SEL_RAW,   // first frame: raw depth, no clamp
    SEL_AVG,   // both inside range: running average
    SEL_NEW,   // old background unreliable: take new depth
    SEL_KEEP   // new depth unreliable: keep old background
  } dba_sel_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_reliable;
    logic [CFG_W-1:0] max_reliable;
  } dba_cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [DEPTH_W-1:0] depth;
    logic               ff;    // first frame already done for this pixel
    logic               inr;   // index lies inside the frame store
  } dba_item_t;

  typedef struct packed {
    logic             valid;
    logic             inr;
    logic [IDX_W-1:0] idx;
  } dba_tag_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [DEPTH_W-1:0] data;
  } dba_wr_t;

endpackage

FILE: hw/rtl/dba_if.sv
// Channel interfaces: pixel input, background result and register write.
// Depends on dba_pkg for field widths.
interface dba_in_if;
  logic                        valid;
  logic                        ready;
  logic [dba_pkg::IDX_W-1:0]   pixel_index;
  logic [dba_pkg::DEPTH_W-1:0] depth_mm;
  logic                        frame_end;
  modport source (output valid, pixel_index, depth_mm, frame_end, input ready);
  modport sink   (input valid, pixel_index, depth_mm, frame_end, output ready);
endinterface

interface dba_out_if;
  logic                        valid;
  logic                        ready;
  logic [dba_pkg::DEPTH_W-1:0] background_mm;
  logic                        background_known;
  modport source (output valid, background_mm, background_known, input ready);
  modport sink   (input valid, background_mm, background_known, output ready);
endinterface

interface dba_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dba_pkg::CFG_IDX_W-1:0] index;
  logic [dba_pkg::CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/dba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/dba_cfg.sv
// Reliable-range registers behind the configuration write channel.
// Depends on dba_pkg and dba_cfg_if.
module dba_cfg (
  input  logic               clk,
  input  logic               rst_n,
  dba_cfg_if.sink            cfg_if,
  output dba_pkg::dba_cfg_t  cfg
);

  dba_pkg::dba_cfg_t cfg_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_reliable <= 15'd500;
      cfg_r.max_reliable <= 15'd4500;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        dba_pkg::REG_MIN_RELIABLE: cfg_r.min_reliable <= cfg_if.data;
        dba_pkg::REG_MAX_RELIABLE: cfg_r.max_reliable <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/dba_update.sv
// Background update datapath: range checks and weighted sum, reciprocal
// divide, selection and clamp, then the result register. Depends on dba_pkg.
module dba_update (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              s1_valid,
  input  dba_pkg::dba_item_t                s1_item,
  input  logic [dba_pkg::DEPTH_W-1:0]       bg_raw,
  input  dba_pkg::dba_cfg_t                 cfg,
  output dba_pkg::dba_tag_t                 s2_tag,
  output dba_pkg::dba_tag_t                 s3_tag,
  output dba_pkg::dba_wr_t                  wr,
  output logic                              out_valid,
  output logic [dba_pkg::DEPTH_W-1:0]       out_bg,
  output logic                              out_known
);

  localparam int DW = dba_pkg::DEPTH_W;

  function automatic logic strictly_inside(logic [DW-1:0] v, dba_pkg::dba_cfg_t c);
    return (v > DW'(c.min_reliable)) && (v < DW'(c.max_reliable));
  endfunction

  // ---- stage 1: old background, range checks, weighted sum
  logic [DW-1:0]             s1_bg;
  logic                      bg_ok;
  logic                      d_ok;
  dba_pkg::dba_sel_t         sel_nxt;
  logic [dba_pkg::SUM_W-1:0] sum_nxt;

  always_comb begin
    s1_bg = s1_item.inr ? bg_raw : '0;
    bg_ok = strictly_inside(s1_bg, cfg);
    d_ok  = strictly_inside(s1_item.depth, cfg);
    if (!s1_item.ff) begin
      sel_nxt = dba_pkg::SEL_RAW;
    end else if (bg_ok && d_ok) begin
      sel_nxt = dba_pkg::SEL_AVG;
    end else if (!bg_ok) begin
      sel_nxt = dba_pkg::SEL_NEW;
    end else begin
      sel_nxt = dba_pkg::SEL_KEEP;
    end
    sum_nxt = dba_pkg::SUM_W'(s1_bg) * dba_pkg::SUM_W'(dba_pkg::AVG_WEIGHT)
            + dba_pkg::SUM_W'(s1_item.depth) + dba_pkg::SUM_W'(dba_pkg::ROUND_HALF);
  end

  logic                      s2_valid_r;
  dba_pkg::dba_item_t        s2_item_r;
  logic [DW-1:0]             s2_bg_r;
  dba_pkg::dba_sel_t         s2_sel_r;
  logic [dba_pkg::SUM_W-1:0] s2_sum_r;

  // ---- stage 2: divide by 100 through reciprocal multiply
  logic [dba_pkg::PROD_W-1:0] prod;
  logic [DW-1:0]              quot_nxt;

  assign prod     = dba_pkg::PROD_W'(s2_sum_r) * dba_pkg::PROD_W'(dba_pkg::RECIP_M);
  assign quot_nxt = prod[dba_pkg::RECIP_SHIFT +: DW];

  logic               s3_valid_r;
  dba_pkg::dba_item_t s3_item_r;
  logic [DW-1:0]      s3_bg_r;
  dba_pkg::dba_sel_t  s3_sel_r;
  logic [DW-1:0]      s3_quot_r;

  // ---- stage 3: select, clamp to unknown mark, range flag
  logic [DW-1:0] nv_sel;
  logic [DW-1:0] nv;
  logic          known_nxt;

  always_comb begin
    case (s3_sel_r)
      dba_pkg::SEL_RAW:  nv_sel = s3_item_r.depth;
      dba_pkg::SEL_AVG:  nv_sel = s3_quot_r;
      dba_pkg::SEL_NEW:  nv_sel = s3_item_r.depth;
      dba_pkg::SEL_KEEP: nv_sel = s3_bg_r;
      default:           nv_sel = s3_item_r.depth;
    endcase
    nv = nv_sel;
    if (s3_item_r.ff &&
        ((nv_sel < DW'(cfg.min_reliable)) || (nv_sel > DW'(cfg.max_reliable)))) begin
      nv = {cfg.max_reliable, 1'b0};
    end
    known_nxt = (nv >= DW'(cfg.min_reliable)) && (nv <= DW'(cfg.max_reliable));
  end

  logic          out_valid_r;
  logic [DW-1:0] out_bg_r;
  logic          out_known_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r  <= s1_valid;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item_r   <= s1_item;
      s2_bg_r     <= s1_bg;
      s2_sel_r    <= sel_nxt;
      s2_sum_r    <= sum_nxt;
      s3_item_r   <= s2_item_r;
      s3_bg_r     <= s2_bg_r;
      s3_sel_r    <= s2_sel_r;
      s3_quot_r   <= quot_nxt;
      out_bg_r    <= nv;
      out_known_r <= known_nxt;
    end
  end

  assign s2_tag = '{valid: s2_valid_r, inr: s2_item_r.inr, idx: s2_item_r.idx};
  assign s3_tag = '{valid: s3_valid_r, inr: s3_item_r.inr, idx: s3_item_r.idx};

  // write-back happens as the word moves into the result register
  assign wr = '{en: adv && s3_valid_r && s3_item_r.inr, idx: s3_item_r.idx, data: nv};

  assign out_valid = out_valid_r;
  assign out_bg    = out_bg_r;
  assign out_known = out_known_r;

endmodule

FILE: hw/rtl/depth_background_accumulator.sv
// Depth background accumulator, top level.
// Depends on dba_pkg, dba_if, dba_ram, dba_cfg and dba_update.

// One depth pixel per clock is taken in unless the block holds it off, and
// one background word per pixel comes out, in order (store read at the
// accepting edge, then weighted sum, reciprocal multiply, select/clamp into
// the result register). The store is a FRAME_PIXELS x 16 RAM with one write
// and one registered read port; each pixel is a read-modify-write of its own
// entry. Sustained rate is one word per cycle while the result side takes
// words and indices differ from those in flight; a pixel whose index is in
// flight is held off (ready low) until that entry has been written back.
// The store is not cleared after reset: the first frame fills it. The user
// must write the reliable-range registers through the cfg channel only
// while the block is idle; the block itself does not enforce this.
module depth_background_accumulator #(
  parameter int FRAME_PIXELS = 262144
) (
  input  logic       clk,
  input  logic       rst_n,
  dba_in_if.sink     in_if,
  dba_out_if.source  out_if,
  dba_cfg_if.sink    cfg_if
);

  localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int IW = dba_pkg::IDX_W;

  dba_pkg::dba_cfg_t cfg;

  dba_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // ---- pipeline control: everything advances unless the result word is stuck
  logic adv;
  logic hazard;
  logic accept;
  logic out_valid;

  assign adv = !out_valid || out_if.ready;

  // ---- stage 1 registers (item waiting for its store read)
  logic               s1_valid_r;
  dba_pkg::dba_item_t s1_item_r;
  dba_pkg::dba_tag_t  s2_tag;
  dba_pkg::dba_tag_t  s3_tag;
  dba_pkg::dba_wr_t   wr;

  // Same-index interlock: an entry still in flight must be written back
  // before it is read again.
  always_comb begin
    hazard = (s1_valid_r && s1_item_r.inr && (s1_item_r.idx == in_if.pixel_index))
          || (s2_tag.valid && s2_tag.inr && (s2_tag.idx == in_if.pixel_index))
          || (s3_tag.valid && s3_tag.inr && (s3_tag.idx == in_if.pixel_index));
  end

  assign in_if.ready = adv && !hazard;
  assign accept      = in_if.valid && in_if.ready;

  // first frame mark: set once the frame_end word has been taken
  logic ff_r;
  logic in_inr;

  assign in_inr = 32'(in_if.pixel_index) < 32'(FRAME_PIXELS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_r       <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept && in_if.frame_end) begin
        ff_r <= 1'b1;
      end
      if (adv) begin
        s1_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= '{idx: in_if.pixel_index, depth: in_if.depth_mm, ff: ff_r, inr: in_inr};
    end
  end

  // ---- background store
  logic [AW+IW-1:0]              raddr_ext;
  logic [AW+IW-1:0]              waddr_ext;
  logic [dba_pkg::DEPTH_W-1:0]   bg_raw;

  assign raddr_ext = (AW+IW)'(in_if.pixel_index);
  assign waddr_ext = (AW+IW)'(wr.idx);

  dba_ram #(
    .WIDTH (dba_pkg::DEPTH_W),
    .DEPTH (FRAME_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (waddr_ext[AW-1:0]),
    .wdata (wr.data),
    .re    (accept),
    .raddr (raddr_ext[AW-1:0]),
    .rdata (bg_raw)
  );

  // ---- update datapath and result register
  dba_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s1_valid  (s1_valid_r),
    .s1_item   (s1_item_r),
    .bg_raw    (bg_raw),
    .cfg       (cfg),
    .s2_tag    (s2_tag),
    .s3_tag    (s3_tag),
    .wr        (wr),
    .out_valid (out_valid),
    .out_bg    (out_if.background_mm),
    .out_known (out_if.background_known)
  );

  assign out_if.valid = out_valid;

`ifndef NO_ASSERTIONS
  // no two in-flight store entries share an index
  a_uniq_s1_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_item_r.inr && s2_tag.valid && s2_tag.inr)
      |-> (s1_item_r.idx != s2_tag.idx))
    else $error("stage 1 and 2 share a store index");

  a_uniq_s1_s3: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_item_r.inr && s3_tag.valid && s3_tag.inr)
      |-> (s1_item_r.idx != s3_tag.idx))
    else $error("stage 1 and 3 share a store index");

  a_uniq_s2_s3: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_tag.valid && s2_tag.inr && s3_tag.valid && s3_tag.inr)
      |-> (s2_tag.idx != s3_tag.idx))
    else $error("stage 2 and 3 share a store index");

  a_ff_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ff_r |=> ff_r)
    else $error("first frame mark cleared");

  a_out_from_s3: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s3_tag.valid))
    else $error("result word without a stage 3 word");
`endif

endmodule

FILE: sim/depth_background_accumulator_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for depth_background_accumulator: random pixel streams
// scored against a behavioural background model. Needs dba_pkg, dba_if and the RTL.
module depth_background_accumulator_tb;

  // Small store, so one first frame is cheap and high indices fall outside it
  localparam int STORE_PIXELS = 200;
  localparam int PHASE_PIXELS = 114;   // random pixels per register setting
  localparam int RAND_PHASES  = 8;

  typedef struct packed {
    logic [dba_pkg::IDX_W-1:0]   idx;
    logic [dba_pkg::DEPTH_W-1:0] depth;
    logic                        frame_end;
  } pixel_word_t;

  typedef struct packed {
    logic [dba_pkg::DEPTH_W-1:0] bg_mm;
    logic                        known;
  } background_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dba_in_if  pix_ch ();
  dba_out_if res_ch ();
  dba_cfg_if cfg_ch ();

  depth_background_accumulator #(
    .FRAME_PIXELS (STORE_PIXELS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (pix_ch),
    .out_if (res_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Background model: its own copy of the store, the first-frame flag and
  // the reliable range. Range registers only move while the block is idle.
  logic [dba_pkg::DEPTH_W-1:0] background_model [STORE_PIXELS];
  bit                          first_frame_done = 1'b0;
  logic [dba_pkg::CFG_W-1:0]   min_reliable = 15'd500;
  logic [dba_pkg::CFG_W-1:0]   max_reliable = 15'd4500;

  pixel_word_t      pixels_to_send[$];
  background_word_t pending_backgrounds[$];
  int unsigned      recent_idx[$];       // last in-range indices, for hazards

  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 47;
  int          error_count   = 0;
  int          word_count    = 0;

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic bit strictly_reliable(input int unsigned v);
    return v > min_reliable && v < max_reliable;
  endfunction

  // One read-modify-write of the model store; returns the word the block owes
  function automatic background_word_t update_background(input pixel_word_t p);
    int unsigned      old_bg;
    int unsigned      nv;
    bit               in_store;
    background_word_t r;
    in_store = p.idx < STORE_PIXELS;
    old_bg   = in_store ? background_model[p.idx] : 0;
    if (!first_frame_done) begin
      nv = p.depth;                      // first frame: raw copy, no clamp
    end else begin
      if (strictly_reliable(old_bg) && strictly_reliable(p.depth))
        nv = (99 * old_bg + p.depth + 50) / 100;   // halves round up
      else if (!strictly_reliable(old_bg))
        nv = p.depth;
      else
        nv = old_bg;
      if (nv < min_reliable || nv > max_reliable)
        nv = 2 * max_reliable;           // unknown mark
    end
    nv = nv & 32'hFFFF;
    if (in_store)
      background_model[p.idx] = nv[15:0];
    if (p.frame_end)
      first_frame_done = 1'b1;
    r.bg_mm = nv[15:0];
    r.known = nv >= min_reliable && nv <= max_reliable;
    return r;
  endfunction

  // Depth picker: mostly inside the range so the average path gets exercised,
  // plus range edges, the 16-bit extremes and plain noise.
  function automatic logic [15:0] pick_depth(input int unsigned lo, input int unsigned hi);
    int unsigned sel;
    int          k;
    int          v;
    sel = $urandom_range(99);
    if (sel < 55 && hi > lo + 1)
      return 16'($urandom_range(hi - 1, lo + 1));
    if (sel < 72) begin
      k = $urandom_range(5);
      v = (k < 3 ? int'(lo) : int'(hi)) + (k % 3) - 1;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
    end
    if (sel < 80)
      return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(65535));
  endfunction

  function automatic pixel_word_t random_pixel(input int unsigned lo, input int unsigned hi);
    pixel_word_t p;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15 && recent_idx.size() > 0) begin
      // reuse an index still in flight to provoke the hold-off
      p.idx = dba_pkg::IDX_W'(recent_idx[$urandom_range(recent_idx.size() - 1)]);
    end else if (sel < 25) begin
      p.idx = dba_pkg::IDX_W'($urandom_range(2**dba_pkg::IDX_W - 1, STORE_PIXELS));
    end else begin
      p.idx = dba_pkg::IDX_W'($urandom_range(STORE_PIXELS - 1));
    end
    if (p.idx < STORE_PIXELS) begin
      recent_idx.push_back(p.idx);
      if (recent_idx.size() > 3) void'(recent_idx.pop_front());
    end
    p.depth     = pick_depth(lo, hi);
    p.frame_end = ($urandom_range(49) == 0);
    return p;
  endfunction

  // Pixel driver: holds a word until it is taken, then may idle before the next.
  // The model is advanced at the edge where the word is accepted.
  always @(posedge clk) begin : drive_pixels
    pixel_word_t sent;
    pixel_word_t nxt;
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        sent.idx       = pix_ch.pixel_index;
        sent.depth     = pix_ch.depth_mm;
        sent.frame_end = pix_ch.frame_end;
        pending_backgrounds.push_back(update_background(sent));
      end
      if (!pix_ch.valid || pix_ch.ready) begin
        if (pixels_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pixels_to_send.pop_front();
          pix_ch.valid       <= 1'b1;
          pix_ch.pixel_index <= nxt.idx;
          pix_ch.depth_mm    <= nxt.depth;
          pix_ch.frame_end   <= nxt.frame_end;
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    if (!rst_n)
      res_ch.ready <= 1'b0;
    else
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Scoreboard: every accepted word against the oldest expectation
  always @(posedge clk) begin : check_backgrounds
    background_word_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_backgrounds.size() == 0) begin
        report_error($sformatf("unexpected word %0d, background_mm %0d",
                               word_count, res_ch.background_mm));
      end else begin
        want = pending_backgrounds.pop_front();
        if (res_ch.background_mm !== want.bg_mm)
          report_error($sformatf("word %0d background_mm got %0d want %0d",
                                 word_count, res_ch.background_mm, want.bg_mm));
        if (res_ch.background_known !== want.known)
          report_error($sformatf("word %0d background_known got %0b want %0b",
                                 word_count, res_ch.background_known, want.known));
      end
      word_count++;
    end
  end

  task automatic write_register(input dba_pkg::dba_reg_t which, input int unsigned value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data  <= value[dba_pkg::CFG_W-1:0];
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    if (which == dba_pkg::REG_MIN_RELIABLE)
      min_reliable = value[dba_pkg::CFG_W-1:0];
    else
      max_reliable = value[dba_pkg::CFG_W-1:0];
  endtask

  // Sampled on the falling edge so the queues and valid are settled
  task automatic wait_until_drained();
    do @(negedge clk);
    while (pixels_to_send.size() != 0 || pix_ch.valid !== 1'b0 ||
           pending_backgrounds.size() != 0);
  endtask

  task automatic queue_pixel(input int unsigned idx, input int unsigned depth,
                             input bit fe);
    pixel_word_t p;
    p.idx       = dba_pkg::IDX_W'(idx);
    p.depth     = dba_pkg::DEPTH_W'(depth);
    p.frame_end = fe;
    pixels_to_send.push_back(p);
  endtask

  initial begin : run
    int unsigned order [STORE_PIXELS];
    int unsigned cfg_lo [RAND_PHASES];
    int unsigned cfg_hi [RAND_PHASES];
    int unsigned j;
    int unsigned tmp;
    int unsigned d;
    int unsigned last_idx;

    pix_ch.valid       = 1'b0;
    pix_ch.pixel_index = '0;
    pix_ch.depth_mm    = '0;
    pix_ch.frame_end   = 1'b0;
    res_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = dba_pkg::REG_MIN_RELIABLE;
    cfg_ch.data        = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // First frame under the reset range: every store entry gets written,
    // in shuffled order, with a few outside indices and repeats mixed in.
    // Low entries are seeded for the directed checks that follow.
    for (int i = 0; i < STORE_PIXELS; i++) order[i] = i;
    for (int i = STORE_PIXELS - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    last_idx = 0;
    for (int i = 0; i < STORE_PIXELS; i++) begin
      case (order[i])
        0:       d = 2000;
        1:       d = 0;
        2:       d = 65535;
        3:       d = 500;
        4:       d = 4500;
        6, 7:    d = 1000;
        default: d = ($urandom_range(99) < 80) ? $urandom_range(4499, 501)
                                               : pick_depth(500, 4500);
      endcase
      queue_pixel(order[i], d, 1'b0);
      if (i % 20 == 19)
        queue_pixel($urandom_range(2**dba_pkg::IDX_W - 1, STORE_PIXELS),
                    $urandom_range(65535), 1'b0);
      // back-to-back repeat of an unseeded entry
      if (i % 23 == 11 && order[i] > 7)
        queue_pixel(order[i], $urandom_range(4499, 501), 1'b0);
    end
    // frame end marker still copies raw depth, no clamp
    queue_pixel(5, 65535, 1'b1);
    wait_until_drained();

    // Directed: each update path under the reset range
    queue_pixel(0, 3000, 1'b0);               // both inside: average
    queue_pixel(0, 3000, 1'b0);               // same entry again, in flight
    queue_pixel(1, 1234, 1'b0);               // old background unreliable
    queue_pixel(0, 100, 1'b0);                // new depth unreliable: keep
    queue_pixel(2, 20000, 1'b0);              // taken then clamped to unknown
    queue_pixel(3, 600, 1'b0);                // old sits on min bound
    queue_pixel(4, 4500, 1'b0);               // new sits on max bound
    queue_pixel(5, 0, 1'b0);                  // zero depth, clamped
    queue_pixel(6, 1050, 1'b0);               // exact half rounds up
    queue_pixel(7, 1049, 1'b0);               // just under half rounds down
    queue_pixel(8, 65535, 1'b0);
    queue_pixel(9, 0, 1'b0);
    queue_pixel(STORE_PIXELS, 65535, 1'b1);   // first index past the store
    queue_pixel(2**dba_pkg::IDX_W - 1, 3000, 1'b0);
    queue_pixel(2**(dba_pkg::IDX_W - 1), 501, 1'b0);
    queue_pixel(6, 4499, 1'b0);
    queue_pixel(6, 501, 1'b0);
    queue_pixel(STORE_PIXELS - 1, 499, 1'b0);
    queue_pixel(STORE_PIXELS - 1, 4501, 1'b1);
    wait_until_drained();

    // Range settings: nominal, widest, inverted, collapsed, both extremes,
    // then two random ones
    cfg_lo = '{500, 0, 32767, 1200, 0, 32767, 0, 0};
    cfg_hi = '{4500, 32767, 0, 1200, 0, 32767, 0, 0};
    for (int p = RAND_PHASES - 2; p < RAND_PHASES; p++) begin
      cfg_lo[p] = $urandom_range(3000);
      cfg_hi[p] = cfg_lo[p] + $urandom_range(6000, 1);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      // block idle again; let any write-back retire before touching the range
      repeat (8) @(posedge clk);
      if (p % 2 == 0) begin
        write_register(dba_pkg::REG_MIN_RELIABLE, cfg_lo[p]);
        write_register(dba_pkg::REG_MAX_RELIABLE, cfg_hi[p]);
      end else begin
        write_register(dba_pkg::REG_MAX_RELIABLE, cfg_hi[p]);
        write_register(dba_pkg::REG_MIN_RELIABLE, cfg_lo[p]);
      end
      // pacing: sender-light, then receiver-light, then flat out
      if (p < 2) begin
        send_idle_pct = 18;
        recv_idle_pct = 47;
      end else if (p < 5) begin
        send_idle_pct = 47;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      recent_idx.delete();
      for (int i = 0; i < PHASE_PIXELS; i++)
        pixels_to_send.push_back(random_pixel(cfg_lo[p], cfg_hi[p]));
      wait_until_drained();
    end

    // pipeline is four deep; allow a margin for stray words
    repeat (12) @(posedge clk);
    if (pending_backgrounds.size() != 0)
      report_error($sformatf("%0d words never arrived", pending_backgrounds.size()));

    if (error_count == 0) begin
      $display("depth_background_accumulator verification clean");
    end else begin
      $display("depth_background_accumulator verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("depth_background_accumulator verification failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/dba_pkg.sv
hw/rtl/dba_if.sv
hw/rtl/dba_ram.sv
hw/rtl/dba_cfg.sv
hw/rtl/dba_update.sv
hw/rtl/depth_background_accumulator.sv
sim/depth_background_accumulator_tb.sv
